// ----- rtl/core/lrast_pkg.sv -----
package lrast_pkg;

   localparam int COORD_BITS      = 16;
   localparam int CFG_W           = 13;
   localparam int CSR_IDX_W       = 2;
   localparam int ADDR_W          = 24;
   localparam int COLOR_W         = 32;
   localparam int DX_W            = COORD_BITS + 1;
   localparam int NDY_W           = COORD_BITS + 2;
   localparam int ERR_W           = COORD_BITS + 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef struct packed {
      op_type                         operation;
      logic signed [COORD_BITS-1:0]   x_start;
      logic signed [COORD_BITS-1:0]   y_start;
      logic signed [COORD_BITS-1:0]   x_end;
      logic signed [COORD_BITS-1:0]   y_end;
      logic [COLOR_W-1:0]             line_color;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]   pixel_x;
      logic signed [COORD_BITS-1:0]   pixel_y;
      logic [ADDR_W-1:0]              pixel_address;
      logic [COLOR_W-1:0]             pixel_color;
      logic                           write_enable;
      logic                           last;
   } rsp_type;

   typedef struct packed {
      op_type                         operation;
      logic signed [COORD_BITS-1:0]   cur_x;
      logic signed [COORD_BITS-1:0]   cur_y;
      logic signed [COORD_BITS-1:0]   tgt_x;
      logic signed [COORD_BITS-1:0]   tgt_y;
      logic [DX_W-1:0]                delta_x;
      logic signed [NDY_W-1:0]        neg_delta_y;
      logic                           x_direction;
      logic                           y_direction;
      logic signed [ERR_W-1:0]        error_term;
      logic [COLOR_W-1:0]             color;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic load;
      logic emit;
   } bk_stat_type;

endpackage

// ----- rtl/core/lrast_front.sv -----
module lrast_front
   import lrast_pkg::*;
(
   input  req_type req_data,
   output cmd_type cmd_data
);

   logic signed [DX_W-1:0]  x_diff;
   logic signed [DX_W-1:0]  y_diff;
   logic                    x_fwd;
   logic                    y_fwd;
   logic [DX_W-1:0]         abs_dx;
   logic [DX_W-1:0]         abs_dy;
   logic signed [NDY_W-1:0] ndy;

   always_comb begin
      x_diff = DX_W'(req_data.x_end) - DX_W'(req_data.x_start);
      y_diff = DX_W'(req_data.y_end) - DX_W'(req_data.y_start);
      x_fwd  = req_data.x_start < req_data.x_end;
      y_fwd  = req_data.y_start < req_data.y_end;
      abs_dx = x_fwd ? $unsigned(x_diff) : $unsigned(-x_diff);
      abs_dy = y_fwd ? $unsigned(y_diff) : $unsigned(-y_diff);
      ndy    = -$signed({1'b0, abs_dy});

      cmd_data.operation   = req_data.operation;
      cmd_data.cur_x       = req_data.x_start;
      cmd_data.cur_y       = req_data.y_start;
      cmd_data.tgt_x       = req_data.x_end;
      cmd_data.tgt_y       = req_data.y_end;
      cmd_data.delta_x     = abs_dx;
      cmd_data.neg_delta_y = ndy;
      cmd_data.x_direction = !x_fwd;
      cmd_data.y_direction = !y_fwd;
      cmd_data.error_term  = $signed(ERR_W'(abs_dx)) + ERR_W'(ndy);
      cmd_data.color       = req_data.line_color;
   end

endmodule

// ----- rtl/core/lrast_queue.sv -----
module lrast_queue
   import lrast_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push_data,
   input  logic    push_valid,
   output logic    push_ready,
   output cmd_type pop_data,
   output logic    pop_valid,
   input  logic    pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/lrast_back.sv -----
module lrast_back
   import lrast_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd_data,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  logic [CFG_W-1:0]  frame_width,
   input  logic [CFG_W-1:0]  frame_height,
   output rsp_type           rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bk_stat_type       stat
);

   localparam int E2_W  = ERR_W + 1;
   localparam int CMP_W = COORD_BITS + CFG_W;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COLOR_W-1:0]           color;
      logic                         visible;
      logic                         last;
   } pix_type;

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_x_in;
   logic signed [COORD_BITS-1:0] tgt_y_ff, tgt_y_in;
   logic [DX_W-1:0]              delta_x_ff, delta_x_in;
   logic signed [NDY_W-1:0]      neg_delta_y_ff, neg_delta_y_in;
   logic                         x_direction_ff, x_direction_in;
   logic                         y_direction_ff, y_direction_in;
   logic signed [ERR_W-1:0]      error_term_ff, error_term_in;
   logic [COLOR_W-1:0]           color_ff, color_in;
   logic                         active_ff, active_in;

   pix_type p1_ff, p1_in;
   logic    p1_valid_ff, p1_valid_in;
   rsp_type p2_ff, p2_in;
   logic    p2_valid_ff, p2_valid_in;
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;

   logic                    is_load;
   logic                    pop;
   logic                    emit;
   logic                    p1_ready;
   logic                    p2_ready;
   logic                    out_ready;
   logic signed [E2_W-1:0]  e2;
   logic signed [E2_W-1:0]  ndy_ext;
   logic signed [E2_W-1:0]  dx_ext;
   logic signed [ERR_W-1:0] add_x;
   logic signed [ERR_W-1:0] add_y;
   logic                    x_cond;
   logic                    y_cond;
   logic                    x_done;
   logic                    y_done;
   logic                    step_x;
   logic                    step_y;
   logic                    x_in_frame;
   logic                    y_in_frame;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign p2_ready  = !p2_valid_ff || out_ready;
   assign p1_ready  = !p1_valid_ff || p2_ready;
   assign is_load   = cmd_data.operation == OP_LOAD;
   assign cmd_ready = is_load || !active_ff || p1_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign emit      = pop && !is_load && active_ff;

   // walker: one pixel and one error update per step transaction on an active line
   always_comb begin
      e2      = {error_term_ff, 1'b0};
      ndy_ext = E2_W'(neg_delta_y_ff);
      dx_ext  = $signed(E2_W'(delta_x_ff));
      x_cond  = e2 >= ndy_ext;
      x_done  = x_cond && (cur_x_ff == tgt_x_ff);
      step_x  = x_cond && !x_done;
      y_cond  = !x_done && (e2 <= dx_ext);
      y_done  = y_cond && (cur_y_ff == tgt_y_ff);
      step_y  = y_cond && !y_done;
      add_x   = step_x ? ERR_W'(neg_delta_y_ff) : '0;
      add_y   = step_y ? $signed(ERR_W'(delta_x_ff)) : '0;

      x_in_frame = !cur_x_ff[COORD_BITS-1] &&
                   (CMP_W'($unsigned(cur_x_ff)) < CMP_W'(frame_width));
      y_in_frame = !cur_y_ff[COORD_BITS-1] &&
                   (CMP_W'($unsigned(cur_y_ff)) < CMP_W'(frame_height));

      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      tgt_x_in       = tgt_x_ff;
      tgt_y_in       = tgt_y_ff;
      delta_x_in     = delta_x_ff;
      neg_delta_y_in = neg_delta_y_ff;
      x_direction_in = x_direction_ff;
      y_direction_in = y_direction_ff;
      error_term_in  = error_term_ff;
      color_in       = color_ff;
      active_in      = active_ff;

      if (pop && is_load) begin
         cur_x_in       = cmd_data.cur_x;
         cur_y_in       = cmd_data.cur_y;
         tgt_x_in       = cmd_data.tgt_x;
         tgt_y_in       = cmd_data.tgt_y;
         delta_x_in     = cmd_data.delta_x;
         neg_delta_y_in = cmd_data.neg_delta_y;
         x_direction_in = cmd_data.x_direction;
         y_direction_in = cmd_data.y_direction;
         error_term_in  = cmd_data.error_term;
         color_in       = cmd_data.color;
         active_in      = 1'b1;
      end else if (emit) begin
         error_term_in = error_term_ff + add_x + add_y;
         if (step_x) begin
            cur_x_in = x_direction_ff ? cur_x_ff - COORD_BITS'(1)
                                      : cur_x_ff + COORD_BITS'(1);
         end
         if (step_y) begin
            cur_y_in = y_direction_ff ? cur_y_ff - COORD_BITS'(1)
                                      : cur_y_ff + COORD_BITS'(1);
         end
         if (x_done || y_done) begin
            active_in = 1'b0;
         end
      end
   end

   // pixel pipeline: walker -> multiply -> address add
   always_comb begin
      p1_valid_in = p1_ready ? emit : p1_valid_ff;
      p1_in       = p1_ff;
      if (emit) begin
         p1_in.x       = cur_x_ff;
         p1_in.y       = cur_y_ff;
         p1_in.color   = color_ff;
         p1_in.visible = x_in_frame && y_in_frame;
         p1_in.last    = x_done || y_done;
      end

      p2_valid_in = p2_ready ? p1_valid_ff : p2_valid_ff;
      p2_in       = p2_ff;
      if (p2_ready && p1_valid_ff) begin
         p2_in.pixel_x       = p1_ff.x;
         p2_in.pixel_y       = p1_ff.y;
         p2_in.pixel_address = p1_ff.visible ?
            ADDR_W'(ADDR_W'($unsigned(p1_ff.y)) * ADDR_W'(frame_width)) : '0;
         p2_in.pixel_color   = p1_ff.color;
         p2_in.write_enable  = p1_ff.visible;
         p2_in.last          = p1_ff.last;
      end

      out_valid_in = out_ready ? p2_valid_ff : out_valid_ff;
      out_in       = out_ff;
      if (out_ready && p2_valid_ff) begin
         out_in = p2_ff;
         if (p2_ff.write_enable) begin
            out_in.pixel_address = p2_ff.pixel_address + ADDR_W'($unsigned(p2_ff.pixel_x));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      tgt_x_ff       <= tgt_x_in;
      tgt_y_ff       <= tgt_y_in;
      delta_x_ff     <= delta_x_in;
      neg_delta_y_ff <= neg_delta_y_in;
      x_direction_ff <= x_direction_in;
      y_direction_ff <= y_direction_in;
      error_term_ff  <= error_term_in;
      color_ff       <= color_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      out_ff         <= out_in;
   end

   assign rsp_data    = out_ff;
   assign rsp_valid   = out_valid_ff;
   assign stat.active = active_ff;
   assign stat.load   = pop && is_load;
   assign stat.emit   = emit;

endmodule

// ----- rtl/core/line_rasterizer_unit.sv -----
// A step transaction's pixel passes, after acceptance, through the command queue,
// the walker register, the multiply register and the output register.
// Throughput: one transaction per cycle, loads and steps alike, unless a step
// waits on a stalled pixel pipeline; the error/coordinate recurrence sets it.
// Reset (synchronous): queue and pipeline empty, no line active,
// frame size 640 x 480.
module line_rasterizer_unit
   import lrast_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   output rsp_type              rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 csr_valid,
   output logic                 csr_ready
);

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;

   cmd_type     front_cmd;
   cmd_type     queue_cmd;
   logic        queue_valid;
   logic        queue_ready;
   bk_stat_type bk_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   lrast_front u_front (
      .req_data (req_data),
      .cmd_data (front_cmd)
   );

   lrast_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (front_cmd),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .pop_data   (queue_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready)
   );

   lrast_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_data     (queue_cmd),
      .cmd_valid    (queue_valid),
      .cmd_ready    (queue_ready),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rsp_data     (rsp_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .stat         (bk_stat)
   );

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_emit_needs_line: assert property (@(posedge clock) disable iff (reset)
      bk_stat.emit |-> bk_stat.active)
      else $error("pixel emitted with no active line");

   a_load_activates: assert property (@(posedge clock) disable iff (reset)
      bk_stat.load |=> bk_stat.active)
      else $error("line not active after load");

endmodule
